// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the console RTL.
// No dependencies; every user includes this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TCW_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_NEVER(lbl, expr, msg)
`endif

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// Shared types, constants and helper functions of the text console writer.
// No dependencies; imported by the controller, the datapath and the top level.
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int CELL_W  = 16;
  localparam int FUNC_W  = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 2'd0,
    FN_HEX   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_PUT_HI,
    ST_PUT_LO,
    ST_SCR_COPY,
    ST_SCR_BLANK,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CH_RAW,
    CH_HI,
    CH_LO
  } chsel_e;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_INIT,
    MOP_CLEAR,
    MOP_COPY,
    MOP_READ
  } mop_e;

  typedef struct packed {
    logic   load_in;
    logic   put;
    chsel_e chsel;
    mop_e   mop;
    logic   cnt_inc;
    logic   cnt_clr;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic put_scroll;
    logic cnt_last;
    logic cnt_copy_end;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_W-1:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, sweep counter,
// attribute register and output register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_wdata_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [CHAR_W-1:0] char_value_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [COL_W-1:0]  cursor_column_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic              did_scroll_o,
  output logic [CELL_W-1:0] cell_value_o
);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END_A = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] CELLS_A    = ADDR_W'(CELLS);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;

  logic [CHAR_W-1:0] attr_q;
  logic [COL_W-1:0]  cursor_x_q, cursor_x_d;
  logic [ROW_W-1:0]  cursor_y_q, cursor_y_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [FUNC_W-1:0] func_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] idx_q;
  logic              oob_q;
  logic              scrolled_q;

  logic              out_valid_q;
  logic [COL_W-1:0]  col_out_q;
  logic [ROW_W-1:0]  row_out_q;
  logic              scr_out_q;
  logic [CELL_W-1:0] cell_out_q;

  logic [CHAR_W-1:0] ch;
  logic              is_nl;
  logic              wrap;
  logic              last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  always_comb begin
    case (cmd_i.chsel)
      CH_HI:   ch = hex_ascii(char_q[7:4]);
      CH_LO:   ch = hex_ascii(char_q[3:0]);
      default: ch = char_q;
    endcase
  end

  assign is_nl    = (ch == NEWLINE_CODE);
  assign wrap     = is_nl || (cursor_x_q >= COL_W'(COLUMNS - 1));
  assign last_row = (cursor_y_q >= ROW_W'(ROWS - 1));
  assign cur_addr = ADDR_W'(cursor_y_q) * COLS_A + ADDR_W'(cursor_x_q);

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (cmd_i.put) begin
      if (wrap) begin
        cursor_x_d = '0;
        if (last_row) begin
          cursor_y_d = ROW_W'(ROWS - 1);
        end else begin
          cursor_y_d = cursor_y_q + 1'b1;
        end
      end else begin
        cursor_x_d = cursor_x_q + 1'b1;
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cnt_q;
    raddr = cnt_q + COLS_A;
    wdata = {attr_q, SPACE_CODE};
    if (cmd_i.put) begin
      we    = !is_nl;
      waddr = cur_addr;
      wdata = {attr_q, ch};
    end else begin
      case (cmd_i.mop)
        MOP_INIT: begin
          we    = 1'b1;
          wdata = {RESET_ATTR, SPACE_CODE};
        end
        MOP_CLEAR: begin
          we = 1'b1;
        end
        MOP_COPY: begin
          we    = (cnt_q != '0);
          waddr = cnt_q - 1'b1;
          wdata = rdata_q;
          re    = (cnt_q != COPY_END_A);
        end
        MOP_READ: begin
          re    = (idx_q < CELLS_A);
          raddr = idx_q;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= RESET_ATTR;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      cnt_q      <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q     <= func_i;
      char_q     <= char_value_i;
      idx_q      <= cell_index_i;
      scrolled_q <= 1'b0;
    end else if (cmd_i.put && wrap && last_row) begin
      scrolled_q <= 1'b1;
    end
    if (cmd_i.mop == MOP_READ) begin
      oob_q <= (idx_q >= CELLS_A);
    end
    if (cmd_i.load_out) begin
      col_out_q  <= cursor_x_q;
      row_out_q  <= cursor_y_q;
      scr_out_q  <= scrolled_q;
      cell_out_q <= (func_e'(func_q) == FN_READ && !oob_q) ? rdata_q : '0;
    end
  end

  assign status_o.put_scroll   = wrap && last_row;
  assign status_o.cnt_last     = (cnt_q == LAST_A);
  assign status_o.cnt_copy_end = (cnt_q == COPY_END_A);
  assign status_o.out_free     = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign cursor_column_o = col_out_q;
  assign cursor_row_o    = row_out_q;
  assign did_scroll_o    = scr_out_q;
  assign cell_value_o    = cell_out_q;

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through cmd_t and reads status_t.
module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  status_t           status_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  logic   lo_pend_q, lo_pend_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FN_PUT:   state_d = ST_PUT;
            FN_HEX:   state_d = ST_PUT_HI;
            FN_CLEAR: state_d = ST_CLEAR;
            FN_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        state_d = status_i.put_scroll ? ST_SCR_COPY : ST_DONE;
      end
      ST_PUT_HI: begin
        state_d = status_i.put_scroll ? ST_SCR_COPY : ST_PUT_LO;
      end
      ST_PUT_LO: begin
        state_d = status_i.put_scroll ? ST_SCR_COPY : ST_DONE;
      end
      ST_SCR_COPY: begin
        if (status_i.cnt_copy_end) state_d = ST_SCR_BLANK;
      end
      ST_SCR_BLANK: begin
        if (status_i.cnt_last) state_d = lo_pend_q ? ST_PUT_LO : ST_DONE;
      end
      ST_CLEAR: begin
        if (status_i.cnt_last) state_d = ST_DONE;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.chsel    = CH_RAW;
    cmd_o.mop      = MOP_NONE;
    lo_pend_d      = lo_pend_q;
    in_stall_o     = (state_q != ST_IDLE);
    unique case (state_q)
      ST_INIT: begin
        cmd_o.mop     = MOP_INIT;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.cnt_clr = status_i.cnt_last;
      end
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
      end
      ST_PUT: begin
        cmd_o.put = 1'b1;
      end
      ST_PUT_HI: begin
        cmd_o.put   = 1'b1;
        cmd_o.chsel = CH_HI;
        lo_pend_d   = 1'b1;
      end
      ST_PUT_LO: begin
        cmd_o.put   = 1'b1;
        cmd_o.chsel = CH_LO;
        lo_pend_d   = 1'b0;
      end
      ST_SCR_COPY: begin
        cmd_o.mop     = MOP_COPY;
        cmd_o.cnt_inc = !status_i.cnt_copy_end;
      end
      ST_SCR_BLANK, ST_CLEAR: begin
        cmd_o.mop     = MOP_CLEAR;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.cnt_clr = status_i.cnt_last;
      end
      ST_READ: begin
        cmd_o.mop = MOP_READ;
      end
      ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o.mop = MOP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      lo_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lo_pend_q <= lo_pend_d;
    end
  end

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// Top level of the 80 by 25 text console writer.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and assert_macros.svh.

// One operation is taken at a time. After reset the block sweeps the 2000-cell
// screen memory to blanks with attribute 7, one cell a cycle, and holds
// in_stall_o high until the sweep is done. A hex byte writes its high digit
// and then its low digit. Every scroll copies the rows up one row through the
// memory's read and write ports, then blanks the last row; a clear screen
// blanks every cell. The result beat waits in an output register, so the next
// operation can be accepted while it is held by out_stall_i.
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [CHAR_W-1:0] char_value_i,
  input  logic [ADDR_W-1:0] cell_index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [COL_W-1:0]  cursor_column_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic              did_scroll_o,
  output logic [CELL_W-1:0] cell_value_o
);

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .char_value_i    (char_value_i),
    .cell_index_i    (cell_index_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o),
    .did_scroll_o    (did_scroll_o),
    .cell_value_o    (cell_value_o)
  );

  `TCW_ASSERT(a_cursor_range, out_valid_o |-> (cursor_column_o < COL_W'(COLUMNS)) && (cursor_row_o < ROW_W'(ROWS)), "cursor out of range")
  `TCW_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o, "second beat accepted while busy")
  `TCW_ASSERT(a_scroll_last_row, (out_valid_o && did_scroll_o) |-> (cursor_row_o == ROW_W'(ROWS - 1)), "scroll left cursor off last row")
  `TCW_NEVER(a_put_and_sweep, cmd.put && (cmd.mop != MOP_NONE), "character write collides with a sweep")

endmodule
